// File: hdl/yuv420_planar_rotate_addresser_defines.svh
// Assertion macros used by the rotate addresser queue.
`ifndef YUV420_PLANAR_ROTATE_ADDRESSER_DEFINES_SVH
`define YUV420_PLANAR_ROTATE_ADDRESSER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define YROT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define YROT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hdl/yrot_pkg.sv
// Types and constants of the YUV 4:2:0 rotate addresser.
package yrot_pkg;

	localparam int CFG_W    = 13;
	localparam int BYTE_W   = 8;
	localparam int OFF_W    = 24;
	localparam int PROD_W   = 2 * CFG_W;

	localparam logic [CFG_W-1:0] RESET_DIM = CFG_W'(64);

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_PITCH  = 2'd3
	} reg_idx_t;

	// Rotation angles in degrees; flip reverses the row order only, not a 180 rotation.
	typedef enum logic [1:0] {
		MODE_COPY   = 2'd0,
		MODE_ROT90  = 2'd1,
		MODE_FLIP   = 2'd2,
		MODE_ROT270 = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PLANE_Y = 2'd0,
		PLANE_U = 2'd1,
		PLANE_V = 2'd2
	} plane_t;

	// One classified byte: offset = mul_a * mul_b + addend.
	typedef struct packed {
		plane_t              plane;
		logic [CFG_W-1:0]    mul_a;
		logic [CFG_W-1:0]    mul_b;
		logic [CFG_W-1:0]    addend;
		logic [BYTE_W-1:0]   sample;
		logic                last;
	} entry_t;

endpackage

// File: hdl/yrot_in_if.sv
// Source byte stream channel.
interface yrot_in_if import yrot_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] source_byte;

	modport source(output valid, source_byte, input ready);
	modport sink(input valid, source_byte, output ready);
endinterface

// File: hdl/yrot_out_if.sv
// Result stream channel.
interface yrot_out_if import yrot_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        plane_select;
	logic [OFF_W-1:0]  dest_offset;
	logic [BYTE_W-1:0] sample_out;
	logic              frame_end;

	modport source(output valid, plane_select, dest_offset, sample_out, frame_end, input ready);
	modport sink(input valid, plane_select, dest_offset, sample_out, frame_end, output ready);
endinterface

// File: hdl/yrot_cfg_if.sv
// Configuration register write channel.
interface yrot_cfg_if import yrot_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       reg_index;
	logic [CFG_W-1:0] wr_data;

	modport source(output valid, reg_index, wr_data, input ready);
	modport sink(input valid, reg_index, wr_data, output ready);
endinterface

// File: hdl/yuv420_planar_rotate_addresser.sv
// Each byte passes the queue, the 13x13 multiply stage and the output register.
// Throughput: one byte per cycle unless dst stalls; multiply stage and output
// register each take one item per cycle, and a four-entry queue absorbs stalls.
// Bytes in padding columns of the 90 and 270 modes give no result.
// Reset (arst_n low) clears counters to the start of luma and loads mode 0
// and 64x64 geometry with pitch 64; no clearing pass.
module yuv420_planar_rotate_addresser import yrot_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	yrot_cfg_if.sink     cfg,
	yrot_in_if.sink      src,
	yrot_out_if.source   dst
);

	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	entry_t q_push_data;
	entry_t q_head;

	// Classify bytes and track position
	yrot_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.src       (src),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	// Decouple front and back
	yrot_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Compute offsets and drive results
	yrot_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.pop     (q_pop),
		.dst     (dst)
	);

endmodule

// File: hdl/yrot_queue.sv
// Short queue between the classifying front end and the address back end.
`include "yuv420_planar_rotate_addresser_defines.svh"

module yrot_queue import yrot_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	`YROT_NEVER(a_push_when_full, push && full, "queue push while full")
	`YROT_NEVER(a_pop_when_empty, pop && empty, "queue pop while empty")
	`YROT_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count above depth")

endmodule

// File: hdl/yrot_front.sv
// Front end: config registers, plane/row/column counters and byte classification.
module yrot_front import yrot_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	yrot_cfg_if.sink     cfg,
	yrot_in_if.sink      src,
	input  logic         q_full,
	output logic         push,
	output entry_t       push_data
);

	localparam int DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
	localparam int CNT_W   = $clog2(DIM_CAP);
	localparam logic [CFG_W-1:0] DIM_CAP_V = CFG_W'(DIM_CAP);

	mode_t              mode_q;
	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;
	logic [CFG_W-1:0]   pitch_q;

	plane_t             plane_q;
	logic [CNT_W-1:0]   row_q;
	logic [CNT_W-1:0]   col_q;

	logic [CFG_W-1:0]   w_full, h_full, p_eff, p_full;
	logic [CFG_W-1:0]   wp, hp, pp;
	logic [CNT_W-1:0]   r, c;
	logic [CFG_W-1:0]   r_x, c_x, h_rev;
	logic [CFG_W:0]     c_inc, r_inc;
	logic               emit;
	logic               accept;

	// Clamp to the legal range and round down to even
	function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] t;
		t = v;
		if (t < CFG_W'(2)) t = CFG_W'(2);
		if (t > DIM_CAP_V) t = DIM_CAP_V;
		return {t[CFG_W-1:1], 1'b0};
	endfunction

	assign cfg.ready = 1'b1;
	assign src.ready = !q_full;
	assign accept    = src.valid && !q_full;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_COPY;
			width_q  <= RESET_DIM;
			height_q <= RESET_DIM;
			pitch_q  <= RESET_DIM;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.reg_index))
				REG_MODE:   mode_q   <= mode_t'(cfg.wr_data[1:0]);
				REG_WIDTH:  width_q  <= cfg.wr_data;
				REG_HEIGHT: height_q <= cfg.wr_data;
				REG_PITCH:  pitch_q  <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// Derive plane geometry and current position
	always_comb begin
		w_full = eff_dim(width_q);
		h_full = eff_dim(height_q);
		p_eff  = eff_dim(pitch_q);
		p_full = (p_eff < w_full) ? w_full : p_eff;
		if (plane_q != PLANE_Y) begin
			wp = w_full >> 1;
			hp = h_full >> 1;
			pp = p_full >> 1;
		end else begin
			wp = w_full;
			hp = h_full;
			pp = p_full;
		end
		c     = (CFG_W'(col_q) >= pp) ? '0 : col_q;
		r     = (CFG_W'(row_q) >= hp) ? '0 : row_q;
		c_x   = CFG_W'(c);
		r_x   = CFG_W'(r);
		h_rev = hp - CFG_W'(1) - r_x;
		c_inc = {1'b0, c_x} + (CFG_W+1)'(1);
		r_inc = {1'b0, r_x} + (CFG_W+1)'(1);
	end

	// Pick the multiply-add operands for the selected mode
	always_comb begin
		emit             = 1'b1;
		push_data.plane  = plane_q;
		push_data.sample = src.source_byte;
		push_data.last   = (plane_q == PLANE_V) && (r_x == hp - CFG_W'(1))
			&& (c_x == pp - CFG_W'(1));
		unique case (mode_q)
			MODE_ROT90: begin
				emit             = (c_x < wp);
				push_data.mul_a  = hp;
				push_data.mul_b  = c_x;
				push_data.addend = h_rev;
			end
			MODE_FLIP: begin
				push_data.mul_a  = pp;
				push_data.mul_b  = h_rev;
				push_data.addend = c_x;
			end
			MODE_ROT270: begin
				emit             = (c_x < wp);
				push_data.mul_a  = wp - CFG_W'(1) - c_x;
				push_data.mul_b  = hp;
				push_data.addend = r_x;
			end
			default: begin
				push_data.mul_a  = pp;
				push_data.mul_b  = r_x;
				push_data.addend = c_x;
			end
		endcase
	end

	assign push = accept && emit;

	// Advance column, row and plane on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_Y;
			row_q   <= '0;
			col_q   <= '0;
		end else if (accept) begin
			if (c_inc >= {1'b0, pp}) begin
				col_q <= '0;
				if (r_inc >= {1'b0, hp}) begin
					row_q   <= '0;
					plane_q <= (plane_q == PLANE_V) ? PLANE_Y : plane_t'(plane_q + 2'd1);
				end else begin
					row_q <= CNT_W'(r_inc);
				end
			end else begin
				row_q <= r;
				col_q <= CNT_W'(c_inc);
			end
		end
	end

endmodule

// File: hdl/yrot_back.sv
// Back end: multiply stage, offset add and output register.
module yrot_back import yrot_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  entry_t       head,
	input  logic         q_empty,
	output logic         pop,
	yrot_out_if.source   dst
);

	logic                valid_s1;
	plane_t              plane_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [CFG_W-1:0]    addend_s1;
	logic [BYTE_W-1:0]   sample_s1;
	logic                last_s1;

	logic                out_valid_q;
	plane_t              out_plane_q;
	logic [OFF_W-1:0]    out_offset_q;
	logic [BYTE_W-1:0]   out_sample_q;
	logic                out_last_q;

	logic                out_free;
	logic                s1_free;
	logic [PROD_W-1:0]   offset_sum;

	assign out_free   = !out_valid_q || dst.ready;
	assign s1_free    = !valid_s1 || out_free;
	assign pop        = !q_empty && s1_free;
	assign offset_sum = prod_s1 + PROD_W'(addend_s1);

	// Stage 1: multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			plane_s1  <= head.plane;
			prod_s1   <= head.mul_a * head.mul_b;
			addend_s1 <= head.addend;
			sample_s1 <= head.sample;
			last_s1   <= head.last;
		end
	end

	// Output register: add and hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_plane_q  <= plane_s1;
			out_offset_q <= offset_sum[OFF_W-1:0];
			out_sample_q <= sample_s1;
			out_last_q   <= last_s1;
		end
	end

	assign dst.valid        = out_valid_q;
	assign dst.plane_select = out_plane_q;
	assign dst.dest_offset  = out_offset_q;
	assign dst.sample_out   = out_sample_q;
	assign dst.frame_end    = out_last_q;

endmodule
